### sv/mwm_pkg.sv
// Shared constants, codes and command/status types for the maze wall merge engine.
// No dependencies; imported by the top level, mwm_ctrl and mwm_datapath.
package mwm_pkg;

    localparam int MAX_COLS   = 16;
    localparam int MAX_ROWS   = 16;
    localparam int RESET_COLS = 16;
    localparam int RESET_ROWS = 16;
    localparam int MIN_DIM    = 2;

    localparam int COL_W   = $clog2(MAX_COLS);
    localparam int ROW_W   = $clog2(MAX_ROWS);
    localparam int ADDR_W  = COL_W + ROW_W;
    localparam int NCELLS  = MAX_COLS * MAX_ROWS;
    localparam int LBL_W   = ADDR_W;
    localparam int WORD_W  = LBL_W + 2;
    localparam int RIGHT_BIT = LBL_W;
    localparam int DOWN_BIT  = LBL_W + 1;
    localparam int CNT_W   = ADDR_W + 1;
    localparam int DIM_W   = 5;
    localparam int PROD_W  = 2 * DIM_W;

    localparam int OP_W     = 2;
    localparam int STATUS_W = 2;
    localparam int CFG_IDX_W = 2;
    localparam int IN_FIELD_W = 4;
    localparam int IN_DATA_W  = 16;
    localparam int OUT_DATA_W = 16;
    localparam int OUT_USED_W = 3 + CNT_W;

    localparam logic [OP_W-1:0] OP_BREAK = 2'd0;
    localparam logic [OP_W-1:0] OP_READ  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    localparam logic [STATUS_W-1:0] ST_BROKEN = 2'd0;
    localparam logic [STATUS_W-1:0] ST_SAME   = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE  = 2'd2;
    localparam logic [STATUS_W-1:0] ST_DONE   = 2'd3;

    localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd1;

    localparam logic [1:0] RD_SCAN = 2'd0;
    localparam logic [1:0] RD_HERE = 2'd1;
    localparam logic [1:0] RD_FAR  = 2'd2;

    typedef struct packed {
        logic                load;
        logic                clear;
        logic [1:0]          rd_sel;
        logic                take_here;
        logic                commit;
        logic                scan_start;
        logic                relabel;
        logic                out_load;
        logic [STATUS_W-1:0] out_status;
        logic                out_walls;
    } cmd_t;

    typedef struct packed {
        logic [OP_W-1:0] op;
        logic            range_bad;
        logic            same_region;
        logic            scan_done;
        logic            dirty;
        logic            out_free;
    } stat_t;

endpackage

### sv/maze_wall_merge_engine.sv
// Top level of the maze wall merge engine: stream ports, config port, ctrl + datapath.
// Depends on mwm_pkg, mwm_ctrl and mwm_datapath.
//
// Usage: each word on the s_ channel is one request (tuser = op): break a wall
// between a cell and its right or lower neighbour, read a cell's two wall bits,
// or clear the maze. Every request returns exactly one word on the m_ channel
// (tuser = status) with the finished flag, wall bits and regions left.
// The cfg channel sets active columns (index 0) and rows (index 1); it is
// always ready. The user must write it only while no request is in flight,
// followed by a clear; the block does not enforce this.
// Sequence: a clear or rejected request goes from decode to the output register;
// a read first reads its cell; a break reads both cells, and a successful break runs
// the relabel scan, which reads one cell label per cycle through the single label
// memory read port. After a config write, the next request that is neither a clear
// nor a merge runs that scan once too to refresh finished.
// One request is in flight at a time; s_tready is high only when idle.
// Reset: all labels become their own cell index, all walls close, 16x16
// active, regions_left 256; no memory clearing pass is needed.
// A stalled receiver holds the result in the output register; the next
// request is accepted meanwhile and waits for the register to drain.
module maze_wall_merge_engine (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [15:0] s_tdata,   // [3:0] cell_col, [7:4] cell_row, [8] wall_down,
                                   // [9] keep_far_label, [15:10] zero
    input  logic [1:0]  s_tuser,   // [1:0] op
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] finished, [1] right_open, [2] down_open,
                                   // [11:3] regions_left, [15:12] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [4:0]  cfg_data
);
    import mwm_pkg::*;

    cmd_t                cmd;
    stat_t               stat;
    logic [STATUS_W-1:0] out_status;
    logic                out_finished, out_right, out_down;
    logic [CNT_W-1:0]    out_regions;

    assign cfg_ready = 1'b1;

    mwm_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mwm_datapath u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_we       (cfg_valid && cfg_ready),
        .cfg_idx      (cfg_index),
        .cfg_val      (cfg_data),
        .in_op        (s_tuser),
        .in_col       (s_tdata[COL_W-1:0]),
        .in_row       (s_tdata[IN_FIELD_W+ROW_W-1:IN_FIELD_W]),
        .in_down      (s_tdata[2*IN_FIELD_W]),
        .in_keep_far  (s_tdata[2*IN_FIELD_W+1]),
        .cmd          (cmd),
        .stat         (stat),
        .out_valid    (m_tvalid),
        .out_ready    (m_tready),
        .out_status   (out_status),
        .out_finished (out_finished),
        .out_right    (out_right),
        .out_down     (out_down),
        .out_regions  (out_regions)
    );

    assign m_tuser = out_status;
    assign m_tdata = {{(OUT_DATA_W-OUT_USED_W){1'b0}}, out_regions, out_down, out_right,
                      out_finished};

endmodule

### sv/mwm_datapath.sv
// Datapath: configuration registers, cell label/wall memory with valid bits,
// relabel scan, region counter and output register. Depends on mwm_pkg.
module mwm_datapath (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           cfg_we,
    input  logic [mwm_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [mwm_pkg::DIM_W-1:0]      cfg_val,
    input  logic [mwm_pkg::OP_W-1:0]       in_op,
    input  logic [mwm_pkg::COL_W-1:0]      in_col,
    input  logic [mwm_pkg::ROW_W-1:0]      in_row,
    input  logic                           in_down,
    input  logic                           in_keep_far,
    input  mwm_pkg::cmd_t                  cmd,
    output mwm_pkg::stat_t                 stat,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [mwm_pkg::STATUS_W-1:0]   out_status,
    output logic                           out_finished,
    output logic                           out_right,
    output logic                           out_down,
    output logic [mwm_pkg::CNT_W-1:0]      out_regions
);
    import mwm_pkg::*;

    logic [DIM_W-1:0]    cols_reg, rows_reg;
    logic [DIM_W-1:0]    nc, nr;
    logic                dirty_reg;

    logic [OP_W-1:0]     op_reg;
    logic [COL_W-1:0]    col_reg;
    logic [ROW_W-1:0]    row_reg;
    logic                down_reg;
    logic                keep_far_reg;

    logic [WORD_W-1:0]   mem [NCELLS];
    logic [NCELLS-1:0]   valid_reg;
    logic [WORD_W-1:0]   rd_word_reg;
    logic                rd_valid_reg;
    logic [ADDR_W-1:0]   rd_addr_reg;
    logic [ADDR_W-1:0]   raddr, waddr, here_addr, far_addr;
    logic [WORD_W-1:0]   wdata, eff_word;
    logic [LBL_W-1:0]    eff_label;
    logic                mem_we;

    logic [WORD_W-1:0]   here_word_reg;
    logic [LBL_W-1:0]    lose_reg, keep_lbl_reg;
    logic                relabel_reg;
    logic [CNT_W-1:0]    count_reg;
    logic                finished_reg;
    logic [PROD_W-1:0]   cell_prod;

    logic [COL_W-1:0]    scan_col_reg;
    logic [ROW_W-1:0]    scan_row_reg;
    logic                scan_issue_reg, scan_pipe_reg;
    logic                first_reg, same_reg;
    logic [LBL_W-1:0]    first_lbl_reg;
    logic                scan_hit, scan_done, same_now;
    logic [LBL_W-1:0]    new_label;
    logic                col_last, row_last;

    logic [DIM_W-1:0]    col_x, row_x, col_x1, row_x1;
    logic                outside, edge_bad, range_bad, same_region;
    logic [COL_W-1:0]    col_p1;
    logic [ROW_W-1:0]    row_p1;

    logic                out_valid_reg;
    logic [STATUS_W-1:0] out_status_reg;
    logic                out_finished_reg, out_right_reg, out_down_reg;
    logic [CNT_W-1:0]    out_regions_reg;

    always_comb
    begin
        if (cols_reg < DIM_W'(MIN_DIM))
            nc = DIM_W'(MIN_DIM);
        else if (cols_reg > DIM_W'(MAX_COLS))
            nc = DIM_W'(MAX_COLS);
        else
            nc = cols_reg;
        if (rows_reg < DIM_W'(MIN_DIM))
            nr = DIM_W'(MIN_DIM);
        else if (rows_reg > DIM_W'(MAX_ROWS))
            nr = DIM_W'(MAX_ROWS);
        else
            nr = rows_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= DIM_W'(RESET_COLS);
            rows_reg <= DIM_W'(RESET_ROWS);
        end
        else if (cfg_we)
        begin
            unique case (cfg_idx)
                CFG_COLS: cols_reg <= cfg_val;
                CFG_ROWS: rows_reg <= cfg_val;
                default:  ;
            endcase
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_reg       <= in_op;
            col_reg      <= in_col;
            row_reg      <= in_row;
            down_reg     <= in_down;
            keep_far_reg <= in_keep_far;
        end
    end

    assign col_x  = DIM_W'(col_reg);
    assign row_x  = DIM_W'(row_reg);
    assign col_x1 = col_x + DIM_W'(1);
    assign row_x1 = row_x + DIM_W'(1);
    assign outside  = (col_x >= nc) || (row_x >= nr);
    assign edge_bad = down_reg ? (row_x1 >= nr) : (col_x1 >= nc);
    assign range_bad = (op_reg == OP_READ) ? outside : (outside || edge_bad);

    assign col_p1    = col_reg + COL_W'(1);
    assign row_p1    = row_reg + ROW_W'(1);
    assign here_addr = {row_reg, col_reg};
    assign far_addr  = down_reg ? {row_p1, col_reg} : {row_reg, col_p1};

    always_comb
    begin
        unique case (cmd.rd_sel)
            RD_HERE: raddr = here_addr;
            RD_FAR:  raddr = far_addr;
            default: raddr = {scan_row_reg, scan_col_reg};
        endcase
    end

    assign eff_word  = rd_valid_reg ? rd_word_reg : {2'b00, rd_addr_reg};
    assign eff_label = eff_word[LBL_W-1:0];

    assign same_region = (down_reg ? here_word_reg[DOWN_BIT] : here_word_reg[RIGHT_BIT])
                         || (here_word_reg[LBL_W-1:0] == eff_label);

    assign scan_hit  = scan_pipe_reg && relabel_reg && (eff_label == lose_reg);
    assign new_label = scan_hit ? keep_lbl_reg : eff_label;
    assign same_now  = first_reg || (same_reg && (new_label == first_lbl_reg));
    assign scan_done = scan_pipe_reg && !scan_issue_reg;

    always_comb
    begin
        mem_we = cmd.commit || scan_hit;
        if (cmd.commit)
        begin
            waddr = here_addr;
            wdata = here_word_reg;
            if (down_reg)
                wdata[DOWN_BIT] = 1'b1;
            else
                wdata[RIGHT_BIT] = 1'b1;
        end
        else
        begin
            waddr = rd_addr_reg;
            wdata = {eff_word[WORD_W-1:LBL_W], keep_lbl_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[waddr] <= wdata;
        rd_word_reg <= mem[raddr];
        rd_addr_reg <= raddr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg    <= '0;
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= valid_reg[raddr];
            if (cmd.clear)
                valid_reg <= '0;
            else if (mem_we)
                valid_reg[waddr] <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.take_here)
            here_word_reg <= eff_word;
        if (cmd.commit)
        begin
            keep_lbl_reg <= keep_far_reg ? eff_label : here_word_reg[LBL_W-1:0];
            lose_reg     <= keep_far_reg ? here_word_reg[LBL_W-1:0] : eff_label;
        end
    end

    assign col_last  = DIM_W'(scan_col_reg) == (nc - DIM_W'(1));
    assign row_last  = DIM_W'(scan_row_reg) == (nr - DIM_W'(1));
    assign cell_prod = PROD_W'(nc) * PROD_W'(nr);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            scan_col_reg   <= '0;
            scan_row_reg   <= '0;
            scan_issue_reg <= 1'b0;
            scan_pipe_reg  <= 1'b0;
            relabel_reg    <= 1'b0;
            first_reg      <= 1'b0;
            same_reg       <= 1'b0;
            first_lbl_reg  <= '0;
            count_reg      <= CNT_W'(NCELLS);
            finished_reg   <= 1'b0;
            dirty_reg      <= 1'b0;
        end
        else
        begin
            scan_pipe_reg <= scan_issue_reg;
            if (cmd.scan_start)
            begin
                scan_col_reg   <= '0;
                scan_row_reg   <= '0;
                scan_issue_reg <= 1'b1;
                relabel_reg    <= cmd.relabel;
                first_reg      <= 1'b1;
            end
            else if (scan_issue_reg)
            begin
                if (col_last)
                begin
                    scan_col_reg <= '0;
                    if (row_last)
                        scan_issue_reg <= 1'b0;
                    else
                        scan_row_reg <= scan_row_reg + ROW_W'(1);
                end
                else
                    scan_col_reg <= scan_col_reg + COL_W'(1);
            end
            if (scan_pipe_reg)
            begin
                first_reg <= 1'b0;
                same_reg  <= same_now;
                if (first_reg)
                    first_lbl_reg <= new_label;
            end
            if (scan_done)
            begin
                finished_reg <= same_now;
                dirty_reg    <= 1'b0;
            end
            if (cmd.commit && (count_reg > CNT_W'(1)))
                count_reg <= count_reg - CNT_W'(1);
            if (cmd.clear)
            begin
                count_reg    <= cell_prod[CNT_W-1:0];
                finished_reg <= 1'b0;
                dirty_reg    <= 1'b0;
            end
            if (cfg_we)
                dirty_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (cmd.out_load)
            out_valid_reg <= 1'b1;
        else if (out_ready)
            out_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_status_reg   <= cmd.out_status;
            out_finished_reg <= finished_reg;
            out_right_reg    <= cmd.out_walls && here_word_reg[RIGHT_BIT];
            out_down_reg     <= cmd.out_walls && here_word_reg[DOWN_BIT];
            out_regions_reg  <= count_reg;
        end
    end

    assign stat.op          = op_reg;
    assign stat.range_bad   = range_bad;
    assign stat.same_region = same_region;
    assign stat.scan_done   = scan_done;
    assign stat.dirty       = dirty_reg;
    assign stat.out_free    = !out_valid_reg || out_ready;

    assign out_valid    = out_valid_reg;
    assign out_status   = out_status_reg;
    assign out_finished = out_finished_reg;
    assign out_right    = out_right_reg;
    assign out_down     = out_down_reg;
    assign out_regions  = out_regions_reg;

endmodule

### sv/mwm_ctrl.sv
// Controller state machine: sequences decode, cell reads, wall commit, scan and output.
// Depends on mwm_pkg; drives mwm_datapath through cmd_t and watches stat_t.
module mwm_ctrl (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           in_valid,
    output logic           in_ready,
    input  mwm_pkg::stat_t stat,
    output mwm_pkg::cmd_t  cmd
);
    import mwm_pkg::*;

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_DISP = 3'd1;
    localparam logic [2:0] S_HERE = 3'd2;
    localparam logic [2:0] S_FAR  = 3'd3;
    localparam logic [2:0] S_SCAN = 3'd4;
    localparam logic [2:0] S_OUT  = 3'd5;

    logic [2:0]          state_reg, state_next;
    logic [STATUS_W-1:0] pend_status_reg, pend_status_next;
    logic                pend_walls_reg, pend_walls_next;

    assign in_ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next       = state_reg;
        pend_status_next = pend_status_reg;
        pend_walls_next  = pend_walls_reg;
        cmd              = '0;
        cmd.rd_sel       = RD_SCAN;
        cmd.out_status   = pend_status_reg;
        cmd.out_walls    = pend_walls_reg;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_DISP;
                end
            end
            S_DISP:
            begin
                pend_walls_next = 1'b0;
                unique case (stat.op)
                    OP_CLEAR:
                    begin
                        cmd.clear        = 1'b1;
                        pend_status_next = ST_DONE;
                        state_next       = S_OUT;
                    end
                    OP_BREAK, OP_READ:
                    begin
                        if (stat.range_bad)
                        begin
                            pend_status_next = ST_RANGE;
                            if (stat.dirty)
                            begin
                                cmd.scan_start = 1'b1;
                                state_next     = S_SCAN;
                            end
                            else
                                state_next = S_OUT;
                        end
                        else
                        begin
                            cmd.rd_sel = RD_HERE;
                            state_next = S_HERE;
                        end
                    end
                    default:
                    begin
                        pend_status_next = ST_RANGE;
                        if (stat.dirty)
                        begin
                            cmd.scan_start = 1'b1;
                            state_next     = S_SCAN;
                        end
                        else
                            state_next = S_OUT;
                    end
                endcase
            end
            S_HERE:
            begin
                cmd.take_here = 1'b1;
                if (stat.op == OP_READ)
                begin
                    pend_walls_next  = 1'b1;
                    pend_status_next = ST_DONE;
                    if (stat.dirty)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                        state_next = S_OUT;
                end
                else
                begin
                    cmd.rd_sel = RD_FAR;
                    state_next = S_FAR;
                end
            end
            S_FAR:
            begin
                if (stat.same_region)
                begin
                    pend_status_next = ST_SAME;
                    if (stat.dirty)
                    begin
                        cmd.scan_start = 1'b1;
                        state_next     = S_SCAN;
                    end
                    else
                        state_next = S_OUT;
                end
                else
                begin
                    cmd.commit       = 1'b1;
                    cmd.scan_start   = 1'b1;
                    cmd.relabel      = 1'b1;
                    pend_status_next = ST_BROKEN;
                    state_next       = S_SCAN;
                end
            end
            S_SCAN:
            begin
                if (stat.scan_done)
                    state_next = S_OUT;
            end
            S_OUT:
            begin
                if (stat.out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_IDLE;
            pend_status_reg <= ST_DONE;
            pend_walls_reg  <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            pend_status_reg <= pend_status_next;
            pend_walls_reg  <= pend_walls_next;
        end
    end

endmodule

### sv/mwm_checker.sv
// Port-level checker for maze_wall_merge_engine, attached by bind.
// Depends only on the top level's ports.
module mwm_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [15:0] s_tdata,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        cfg_valid,
    input logic        cfg_ready,
    input logic [1:0]  cfg_index,
    input logic [4:0]  cfg_data
);

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
        else $error("result word changed while stalled");

    a_regions_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[11:3] != 9'd0)
        else $error("regions_left reached zero");

    a_walls_only_on_read: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && m_tuser != 2'd3 |-> m_tdata[2:1] == 2'b00)
        else $error("wall bits set on a non-read result");

    a_no_instant_result: assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !$rose(m_tvalid))
        else $error("result appeared one cycle after accept");

endmodule

bind maze_wall_merge_engine mwm_checker u_mwm_checker (.*);
